[src/sbafe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbafe_pkg
// shared types, codes and constants of the six-bit armor field extractor
// ----------------------------------------------------------------------------
package sbafe_pkg;

    localparam int STORE_SYMBOLS_DEF = 256;
    localparam int FETCH_MAX         = 32;

    localparam int OPCODE_W  = 2;
    localparam int CHAR_W    = 8;
    localparam int FWIDTH_W  = 6;
    localparam int VALUE_W   = 32;
    localparam int DELIV_W   = 6;
    localparam int STATUS_W  = 2;
    localparam int REMAIN_W  = 11;
    localparam int SYM_W     = 6;
    localparam int SYM_CNT_W = 3;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_HI_A   = 8'h57;
    localparam logic [CHAR_W-1:0] CHAR_LO_B   = 8'h60;
    localparam logic [CHAR_W-1:0] CHAR_HI_B   = 8'h77;
    localparam logic [CHAR_W-1:0] CHAR_OFF_B  = 8'h38;
    localparam logic [CHAR_W-1:0] SYM_MASK    = 8'h3F;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_FETCH  = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BADCHAR   = 2'd1,
        ST_FULL      = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the accepted request
        logic exec;      // apply clear, append or no-op
        logic take;      // move bits from the current source into the accumulator
        logic read_sym;  // read the next stored symbol
        logic set_exh;   // mark the stream as exhausted
        logic out_load;  // load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_fetch;
        logic need_zero;
        logic src_empty;
        logic has_sym;
        logic take_drains;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
    } t_dearmor;

    function automatic t_dearmor dearmor(input logic [CHAR_W-1:0] c);
        t_dearmor d;
        logic [CHAR_W-1:0] diff;
        d.valid = 1'b0;
        diff    = '0;
        if (c >= CHAR_LO_A && c <= CHAR_HI_A) begin
            d.valid = 1'b1;
            diff    = c - CHAR_LO_A;
        end else if (c >= CHAR_LO_B && c <= CHAR_HI_B) begin
            d.valid = 1'b1;
            diff    = c - CHAR_OFF_B;
        end
        d.sym = SYM_W'(diff & SYM_MASK);
        return d;
    endfunction

endpackage
`default_nettype wire

[src/sbafe_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbafe_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sbafe_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[src/sbafe_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbafe_ctrl
// request sequencer: accept, execute, fetch loop, result hand-off
// ----------------------------------------------------------------------------
module sbafe_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire sbafe_pkg::t_sts  i_sts,
    output sbafe_pkg::t_cmd       o_cmd
);

    sbafe_pkg::t_state r_state;
    sbafe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbafe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbafe_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = sbafe_pkg::S_EXEC;
                end
            end
            sbafe_pkg::S_EXEC: begin
                n_state = i_sts.is_fetch ? sbafe_pkg::S_FETCH : sbafe_pkg::S_DONE;
            end
            sbafe_pkg::S_FETCH: begin
                if (i_sts.need_zero) begin
                    n_state = sbafe_pkg::S_DONE;
                end else if (i_sts.src_empty && !i_sts.has_sym) begin
                    n_state = sbafe_pkg::S_DONE;
                end
            end
            sbafe_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = sbafe_pkg::S_IDLE;
                end
            end
            default: n_state = sbafe_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sbafe_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            sbafe_pkg::S_EXEC: begin
                o_cmd.exec = !i_sts.is_fetch;
            end
            sbafe_pkg::S_FETCH: begin
                if (!i_sts.need_zero) begin
                    if (i_sts.src_empty) begin
                        o_cmd.read_sym = i_sts.has_sym;
                        o_cmd.set_exh  = !i_sts.has_sym;
                    end else begin
                        o_cmd.take     = 1'b1;
                        o_cmd.read_sym = i_sts.take_drains && i_sts.has_sym;
                    end
                end
            end
            sbafe_pkg::S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // a symbol read is only ever issued from the fetch loop
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.read_sym |-> r_state == sbafe_pkg::S_FETCH)
        else $error("symbol read outside fetch loop");

    // after a request is taken the next cycle executes it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == sbafe_pkg::S_EXEC)
        else $error("accepted request not executed");

    // a result load always returns to idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_state == sbafe_pkg::S_IDLE)
        else $error("result load did not end the request");

endmodule
`default_nettype wire

[src/sbafe_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbafe_dp
// symbol store, stream counters, bit accumulator and output register
// ----------------------------------------------------------------------------
module sbafe_dp #(
    parameter int STORE_SYMBOLS = sbafe_pkg::STORE_SYMBOLS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [sbafe_pkg::OPCODE_W-1:0] i_opcode,
    input  wire logic [sbafe_pkg::CHAR_W-1:0]   i_char_in,
    input  wire logic [sbafe_pkg::FWIDTH_W-1:0] i_fetch_width,
    input  wire sbafe_pkg::t_cmd                i_cmd,
    output sbafe_pkg::t_sts                     o_sts,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [sbafe_pkg::VALUE_W-1:0]       o_field_value,
    output logic [sbafe_pkg::DELIV_W-1:0]       o_bits_delivered,
    output logic [sbafe_pkg::STATUS_W-1:0]      o_status,
    output logic [sbafe_pkg::REMAIN_W-1:0]      o_bits_remaining
);

    localparam int CW  = $clog2(STORE_SYMBOLS + 1);
    localparam int AW  = $clog2(STORE_SYMBOLS);
    localparam int RW  = CW + 3;
    localparam int SW  = sbafe_pkg::SYM_W;
    localparam int NW  = sbafe_pkg::FWIDTH_W;
    localparam int KW  = sbafe_pkg::SYM_CNT_W;
    localparam int VW  = sbafe_pkg::VALUE_W;

    // request
    sbafe_pkg::t_opcode         r_op;
    logic [sbafe_pkg::CHAR_W-1:0] r_char;
    logic [NW-1:0]              r_need;
    logic [NW-1:0]              n_need_ld;

    // stream state
    logic [CW-1:0]              r_wc;
    logic [CW-1:0]              r_rp;
    logic [SW-1:0]              r_left;
    logic [KW-1:0]              r_lc;
    logic                       r_pend;

    // result being built
    logic [VW-1:0]              r_acc;
    logic [NW-1:0]              r_got;
    sbafe_pkg::t_status         r_status;

    // output register
    logic                       r_out_valid;
    logic [VW-1:0]              r_out_value;
    logic [NW-1:0]              r_out_got;
    sbafe_pkg::t_status         r_out_status;
    logic [sbafe_pkg::REMAIN_W-1:0] r_out_rem;

    logic [SW-1:0]              ram_rdata;
    logic                       ram_we;
    logic                       store_full;
    sbafe_pkg::t_dearmor        dm;

    logic [SW-1:0]              src_bits;
    logic [KW-1:0]              src_cnt;
    logic [KW-1:0]              take;
    logic [KW-1:0]              rest;
    logic [SW-1:0]              piece;
    logic [SW-1:0]              rest_mask;
    logic [SW:0]                take_mask;
    logic [CW-1:0]              pending;
    logic [RW-1:0]              rem_full;

    assign n_need_ld = (i_fetch_width > NW'(sbafe_pkg::FETCH_MAX))
                     ? NW'(sbafe_pkg::FETCH_MAX) : i_fetch_width;

    // current bit source: a freshly read symbol or the leftover bits
    assign src_bits  = r_pend ? ram_rdata : r_left;
    assign src_cnt   = r_pend ? KW'(SW) : r_lc;
    assign take      = (r_need < NW'(src_cnt)) ? r_need[KW-1:0] : src_cnt;
    assign rest      = src_cnt - take;
    assign take_mask = (SW+1)'(((SW+1)'(1) << take) - (SW+1)'(1));
    assign rest_mask = SW'(((SW+1)'(1) << rest) - (SW+1)'(1));
    assign piece     = (src_bits >> rest) & take_mask[SW-1:0];

    assign dm         = sbafe_pkg::dearmor(r_char);
    assign store_full = r_wc >= CW'(STORE_SYMBOLS);
    assign ram_we     = i_cmd.exec && (r_op == sbafe_pkg::OP_APPEND) && dm.valid && !store_full;

    assign pending  = r_wc - r_rp;
    assign rem_full = (RW'(pending) << 2) + (RW'(pending) << 1) + RW'(r_lc);

    assign o_sts.is_fetch    = r_op == sbafe_pkg::OP_FETCH;
    assign o_sts.need_zero   = r_need == '0;
    assign o_sts.src_empty   = src_cnt == '0;
    assign o_sts.has_sym     = r_rp < r_wc;
    assign o_sts.take_drains = (rest == '0) && (r_need > NW'(take));
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    sbafe_ram #(
        .WIDTH (SW),
        .DEPTH (STORE_SYMBOLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wc[AW-1:0]),
        .i_wdata (dm.sym),
        .i_re    (i_cmd.read_sym),
        .i_raddr (r_rp[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= sbafe_pkg::t_opcode'(i_opcode);
            r_char <= i_char_in;
        end
    end

    // stream and accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc     <= '0;
            r_rp     <= '0;
            r_left   <= '0;
            r_lc     <= '0;
            r_pend   <= 1'b0;
            r_need   <= '0;
            r_got    <= '0;
            r_acc    <= '0;
            r_status <= sbafe_pkg::ST_OK;
        end else begin
            if (i_cmd.load) begin
                r_need   <= n_need_ld;
                r_got    <= '0;
                r_acc    <= '0;
                r_status <= sbafe_pkg::ST_OK;
            end
            if (i_cmd.exec) begin
                case (r_op)
                    sbafe_pkg::OP_CLEAR: begin
                        r_wc   <= '0;
                        r_rp   <= '0;
                        r_left <= '0;
                        r_lc   <= '0;
                        r_pend <= 1'b0;
                    end
                    sbafe_pkg::OP_APPEND: begin
                        if (!dm.valid) begin
                            r_status <= sbafe_pkg::ST_BADCHAR;
                        end else if (store_full) begin
                            r_status <= sbafe_pkg::ST_FULL;
                        end else begin
                            r_wc <= r_wc + CW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.take) begin
                r_acc  <= (r_acc << take) | VW'(piece);
                r_left <= src_bits & rest_mask;
                r_lc   <= rest;
                r_need <= r_need - NW'(take);
                r_got  <= r_got + NW'(take);
            end
            if (i_cmd.read_sym) begin
                r_rp   <= r_rp + CW'(1);
                r_pend <= 1'b1;
            end else if (i_cmd.take) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.set_exh) begin
                r_status <= sbafe_pkg::ST_EXHAUSTED;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= r_acc;
            r_out_got    <= r_got;
            r_out_status <= r_status;
            r_out_rem    <= sbafe_pkg::REMAIN_W'(rem_full);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_field_value    = r_out_value;
    assign o_bits_delivered = r_out_got;
    assign o_status         = r_out_status;
    assign o_bits_remaining = r_out_rem;

    // read pointer never passes the write count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= r_wc)
        else $error("read pointer past write count");

    // a pending symbol read only happens once the leftover bits are used up
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_lc == '0)
        else $error("symbol read with leftover bits still held");

    // delivered plus outstanding bits never exceed the fetch limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (NW+1)'(r_got) + (NW+1)'(r_need) <= (NW+1)'(sbafe_pkg::FETCH_MAX))
        else $error("fetch bit accounting broken");

    // an exhausted result leaves nothing behind
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == sbafe_pkg::ST_EXHAUSTED) |-> r_out_rem == '0)
        else $error("exhausted result with bits remaining");

endmodule
`default_nettype wire

[src/six_bit_armor_field_extractor_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// six_bit_armor_field_extractor_core
// de-armors six-bit ascii payload characters into a symbol store and hands
// out msb-first bit fields of up to 32 bits from the stored stream
// ----------------------------------------------------------------------------
//  channel   | direction | width | contents (lsb first)
//  ----------+-----------+-------+-------------------------------------------
//  s_axis_*  | in        | 16    | opcode[1:0] char_in[9:2] fetch_width[15:10]
//  m_axis_*  | out       | 56    | field_value[31:0] bits_delivered[37:32]
//            |           |       | status[39:38] bits_remaining[50:40]
//
//  one request at a time; a request is accepted only while the sequencer idles
//  clear, append and no-op: accept, execute and hand-off per request
//  fetch: accept, execute, the fetch loop and hand-off; the loop reads symbols
//  through the registered store read port, one symbol per cycle, overlapped
//  with the bit take of the previous symbol
//  a stalled result sits in the output register; the next request may be
//  accepted and worked on meanwhile, it waits at hand-off until the register frees
//  reset clears counters, leftover bits and control; store contents are kept
// ----------------------------------------------------------------------------
module six_bit_armor_field_extractor_core #(
    parameter int STORE_SYMBOLS = sbafe_pkg::STORE_SYMBOLS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // request channel
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // opcode[1:0], char_in[9:2], fetch_width[15:10]
    input  wire logic [sbafe_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // result channel
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // field_value[31:0], bits_delivered[37:32], status[39:38],
    // bits_remaining[50:40], zero[55:51]
    output logic [sbafe_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

    localparam int PAD_W = sbafe_pkg::OUT_TDATA_W - sbafe_pkg::VALUE_W - sbafe_pkg::DELIV_W
                         - sbafe_pkg::STATUS_W - sbafe_pkg::REMAIN_W;

    sbafe_pkg::t_cmd cmd;
    sbafe_pkg::t_sts sts;

    logic [sbafe_pkg::VALUE_W-1:0]  field_value;
    logic [sbafe_pkg::DELIV_W-1:0]  bits_delivered;
    logic [sbafe_pkg::STATUS_W-1:0] status;
    logic [sbafe_pkg::REMAIN_W-1:0] bits_remaining;

    // sequencer: one request in flight, fetch loop one step per cycle
    sbafe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // store, counters, accumulator and result register
    sbafe_dp #(
        .STORE_SYMBOLS (STORE_SYMBOLS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_opcode         (s_axis_tdata[1:0]),
        .i_char_in        (s_axis_tdata[9:2]),
        .i_fetch_width    (s_axis_tdata[15:10]),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_field_value    (field_value),
        .o_bits_delivered (bits_delivered),
        .o_status         (status),
        .o_bits_remaining (bits_remaining)
    );

    // result packing, first field in the low bits
    assign m_axis_tdata = {{PAD_W{1'b0}}, bits_remaining, status, bits_delivered, field_value};

endmodule
`default_nettype wire

[verif/tb_six_bit_armor_field_extractor_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_six_bit_armor_field_extractor_core
// self-checking bench: drives clear, append, fetch and no-op requests through
// the request stream, predicts every result with a shadow copy of the symbol
// store and bit pointer, and compares each returned result field by field
// ----------------------------------------------------------------------------
module tb_six_bit_armor_field_extractor_core;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 40;
    localparam int RANDOM_ITEMS    = 440;

    // one expected result, unpacked
    typedef struct packed {
        logic [sbafe_pkg::VALUE_W-1:0]  value;
        logic [sbafe_pkg::DELIV_W-1:0]  delivered;
        sbafe_pkg::t_status             status;
        logic [sbafe_pkg::REMAIN_W-1:0] remaining;
    } t_field_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // opcode[1:0], char_in[9:2], fetch_width[15:10]
    logic [sbafe_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // field_value[31:0], bits_delivered[37:32], status[39:38],
    // bits_remaining[50:40], zero[55:51]
    logic [sbafe_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // shadow of the block's stream state
    logic [sbafe_pkg::SYM_W-1:0] sym_shadow [sbafe_pkg::STORE_SYMBOLS_DEF];
    int               shadow_wr;
    int               shadow_rd;
    int               shadow_left;
    int               shadow_left_n;

    t_field_result pending_fields[$];
    int            mismatch_count = 0;
    int            results_seen = 0;
    int            requests_sent = 0;
    int            quiet_cycles = 0;
    int            rx_stall_left = 0;
    int            rx_gap;
    bit            idle_on = 1'b1;
    bit            hold_off_request = 1'b0;

    six_bit_armor_field_extractor_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // applies one request to the shadow state and returns the result it gives
    function automatic t_field_result predict_extract(
        input sbafe_pkg::t_opcode                op,
        input logic [sbafe_pkg::CHAR_W-1:0]      ch,
        input logic [sbafe_pkg::FWIDTH_W-1:0]    width);
        t_field_result               r;
        logic [63:0]                 acc;
        logic [sbafe_pkg::SYM_W-1:0] sym;
        bit               char_ok;
        bit               dry;
        int               need;
        int               got;
        int               take;
        int               rest;
        r       = '0;
        acc     = '0;
        sym     = '0;
        char_ok = 1'b0;
        dry     = 1'b0;
        got     = 0;
        case (op)
            sbafe_pkg::OP_CLEAR: begin
                shadow_wr     = 0;
                shadow_rd     = 0;
                shadow_left   = 0;
                shadow_left_n = 0;
            end
            sbafe_pkg::OP_APPEND: begin
                if (ch >= sbafe_pkg::CHAR_LO_A && ch <= sbafe_pkg::CHAR_HI_A) begin
                    char_ok = 1'b1;
                    sym     = sbafe_pkg::SYM_W'(ch - sbafe_pkg::CHAR_LO_A);
                end else if (ch >= sbafe_pkg::CHAR_LO_B && ch <= sbafe_pkg::CHAR_HI_B) begin
                    char_ok = 1'b1;
                    sym     = sbafe_pkg::SYM_W'(ch - sbafe_pkg::CHAR_OFF_B);
                end
                // character check wins over the full check
                if (!char_ok) begin
                    r.status = sbafe_pkg::ST_BADCHAR;
                end else if (shadow_wr >= sbafe_pkg::STORE_SYMBOLS_DEF) begin
                    r.status = sbafe_pkg::ST_FULL;
                end else begin
                    sym_shadow[shadow_wr] = sym;
                    shadow_wr++;
                end
            end
            sbafe_pkg::OP_FETCH: begin
                need = (width > sbafe_pkg::FETCH_MAX) ? sbafe_pkg::FETCH_MAX : int'(width);
                while (need > 0 && !dry) begin
                    if (shadow_left_n == 0) begin
                        if (shadow_rd < shadow_wr) begin
                            shadow_left   = sym_shadow[shadow_rd];
                            shadow_left_n = sbafe_pkg::SYM_W;
                            shadow_rd++;
                        end else begin
                            r.status = sbafe_pkg::ST_EXHAUSTED;
                            dry      = 1'b1;
                        end
                    end
                    if (!dry) begin
                        take          = (need < shadow_left_n) ? need : shadow_left_n;
                        rest          = shadow_left_n - take;
                        acc           = (acc << take) |
                                        64'((shadow_left >> rest) & ((1 << take) - 1));
                        shadow_left   = shadow_left & ((1 << rest) - 1);
                        shadow_left_n = rest;
                        need         -= take;
                        got          += take;
                    end
                end
            end
            default: ;
        endcase
        r.value     = acc[sbafe_pkg::VALUE_W-1:0];
        r.delivered = sbafe_pkg::DELIV_W'(got);
        r.remaining = sbafe_pkg::REMAIN_W'(shadow_left_n
                                           + sbafe_pkg::SYM_W * (shadow_wr - shadow_rd));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [sbafe_pkg::CHAR_W-1:0] pick_armor_char();
        if ($urandom_range(0, 1) == 0)
            return sbafe_pkg::CHAR_W'($urandom_range(sbafe_pkg::CHAR_LO_A,
                                                     sbafe_pkg::CHAR_HI_A));
        return sbafe_pkg::CHAR_W'($urandom_range(sbafe_pkg::CHAR_LO_B, sbafe_pkg::CHAR_HI_B));
    endfunction

    // mostly legal widths, sometimes above the cap
    function automatic logic [sbafe_pkg::FWIDTH_W-1:0] pick_fetch_width();
        if ($urandom_range(0, 9) < 9)
            return sbafe_pkg::FWIDTH_W'($urandom_range(0, sbafe_pkg::FETCH_MAX));
        return sbafe_pkg::FWIDTH_W'($urandom_range(sbafe_pkg::FETCH_MAX + 1, 63));
    endfunction

    // offers one request, holds it until accepted, then predicts its result
    task automatic send_request(input sbafe_pkg::t_opcode             op,
                                input logic [sbafe_pkg::CHAR_W-1:0]   ch,
                                input logic [sbafe_pkg::FWIDTH_W-1:0] width);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {width, ch, op};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_fields.push_back(predict_extract(op, ch, width));
        requests_sent++;
    endtask

    // sender pause until the block has returned everything
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_fields.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // range edges, bad characters, zero and oversized fetches, no-op, clear
    task automatic test_directed_cases();
        send_request(sbafe_pkg::OP_NOP,    8'hFF, 6'd63);
        send_request(sbafe_pkg::OP_FETCH,  8'h00, 6'd32);  // empty stream runs dry at once
        send_request(sbafe_pkg::OP_FETCH,  8'h00, 6'd0);
        send_request(sbafe_pkg::OP_APPEND, sbafe_pkg::CHAR_LO_A, 6'd0);
        send_request(sbafe_pkg::OP_APPEND, sbafe_pkg::CHAR_HI_A, 6'd0);
        send_request(sbafe_pkg::OP_APPEND, sbafe_pkg::CHAR_LO_B, 6'd0);
        send_request(sbafe_pkg::OP_APPEND, sbafe_pkg::CHAR_HI_B, 6'd0);
        send_request(sbafe_pkg::OP_APPEND, 8'h2F, 6'd0);   // just below the first range
        send_request(sbafe_pkg::OP_APPEND, 8'h58, 6'd0);   // gap between the ranges
        send_request(sbafe_pkg::OP_APPEND, 8'h5F, 6'd0);
        send_request(sbafe_pkg::OP_APPEND, 8'h78, 6'd0);   // just above the second range
        send_request(sbafe_pkg::OP_APPEND, 8'hFF, 6'd0);
        send_request(sbafe_pkg::OP_APPEND, 8'h00, 6'd0);
        send_request(sbafe_pkg::OP_FETCH,  8'h00, 6'd0);
        send_request(sbafe_pkg::OP_FETCH,  8'h00, 6'd1);
        send_request(sbafe_pkg::OP_FETCH,  8'h00, 6'd5);   // drains the leftover exactly
        send_request(sbafe_pkg::OP_FETCH,  8'hAA, 6'd7);   // spans two symbols
        send_request(sbafe_pkg::OP_NOP,    8'h00, 6'd0);
        send_request(sbafe_pkg::OP_APPEND, 8'h41, 6'd0);
        send_request(sbafe_pkg::OP_APPEND, 8'h6A, 6'd0);
        send_request(sbafe_pkg::OP_FETCH,  8'h00, 6'd63);  // capped, then runs dry
        send_request(sbafe_pkg::OP_FETCH,  8'h00, 6'd1);
        send_request(sbafe_pkg::OP_APPEND, 8'h45, 6'd0);
        send_request(sbafe_pkg::OP_CLEAR,  8'h55, 6'd21);
        send_request(sbafe_pkg::OP_FETCH,  8'h00, 6'd6);
    endtask

    // fills the store to the last entry, overflows it, reads everything back
    task automatic test_full_store();
        send_request(sbafe_pkg::OP_CLEAR, 8'h00, 6'd0);
        repeat (sbafe_pkg::STORE_SYMBOLS_DEF)
            send_request(sbafe_pkg::OP_APPEND, pick_armor_char(), 6'd0);
        send_request(sbafe_pkg::OP_APPEND, pick_armor_char(), 6'd0);  // dropped, store full
        send_request(sbafe_pkg::OP_APPEND, 8'h5A, 6'd0);              // bad char still wins
        send_request(sbafe_pkg::OP_NOP, 8'h00, 6'd0);                 // remaining at its peak
        while (shadow_left_n + sbafe_pkg::SYM_W * (shadow_wr - shadow_rd) > 0)
            send_request(sbafe_pkg::OP_FETCH, 8'h00,
                         ($urandom_range(0, 1) == 0) ? 6'd32 : pick_fetch_width());
        send_request(sbafe_pkg::OP_FETCH, 8'h00, 6'd32);
    endtask

    // long receiver hold-off while requests keep coming, then a full drain
    task automatic test_backpressure();
        idle_on          = 1'b0;
        hold_off_request = 1'b1;
        send_request(sbafe_pkg::OP_CLEAR, 8'h00, 6'd0);
        repeat (6) send_request(sbafe_pkg::OP_APPEND, pick_armor_char(), 6'd0);
        repeat (6) send_request(sbafe_pkg::OP_FETCH, 8'h00,
                                sbafe_pkg::FWIDTH_W'($urandom_range(1, 12)));
        drain_results();
        idle_on = 1'b1;
    endtask

    // mostly well-formed payloads with random content, some noise in between
    task automatic test_random_streams();
        int start_count;
        int payload_len;
        int fetches;
        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 9) < 8);
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 9) < 7)
                    send_request(sbafe_pkg::OP_CLEAR, sbafe_pkg::CHAR_W'($urandom),
                                 sbafe_pkg::FWIDTH_W'($urandom));
                payload_len = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 16)
                                                          : $urandom_range(17, 120);
                repeat (payload_len) begin
                    if ($urandom_range(0, 9) < 9)
                        send_request(sbafe_pkg::OP_APPEND, pick_armor_char(),
                                     sbafe_pkg::FWIDTH_W'($urandom));
                    else
                        send_request(sbafe_pkg::OP_APPEND, sbafe_pkg::CHAR_W'($urandom),
                                     sbafe_pkg::FWIDTH_W'($urandom));
                end
                fetches = $urandom_range(1, payload_len / 3 + 3);
                repeat (fetches)
                    send_request(sbafe_pkg::OP_FETCH, sbafe_pkg::CHAR_W'($urandom),
                                 pick_fetch_width());
            end else begin
                repeat ($urandom_range(1, 8))
                    send_request(sbafe_pkg::t_opcode'($urandom_range(0, 3)),
                                 sbafe_pkg::CHAR_W'($urandom),
                                 sbafe_pkg::FWIDTH_W'($urandom_range(0, 63)));
            end
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what,
                                   input logic [sbafe_pkg::VALUE_W-1:0] expected_val,
                                   input logic [sbafe_pkg::VALUE_W-1:0] actual_val);
        $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                 $time, results_seen, what, expected_val, actual_val);
        mismatch_count++;
    endtask

    // receiver ready: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            rx_stall_left    = HOLD_OFF_CYCLES - 1;
            m_axis_tready   <= 1'b0;
        end else begin
            rx_gap = pick_gap();
            if (rx_gap > 0) begin
                rx_stall_left  = rx_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // compare each returned result against the oldest prediction
    always @(posedge i_clk) begin
        t_field_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_fields.size() == 0) begin
                report_mismatch("result with nothing pending, tdata[31:0]", '0,
                                m_axis_tdata[31:0]);
            end else begin
                exp_r = pending_fields.pop_front();
                if (m_axis_tdata[31:0] !== exp_r.value)
                    report_mismatch("field_value", exp_r.value, m_axis_tdata[31:0]);
                if (m_axis_tdata[37:32] !== exp_r.delivered)
                    report_mismatch("bits_delivered", 32'(exp_r.delivered),
                                    32'(m_axis_tdata[37:32]));
                if (m_axis_tdata[39:38] !== exp_r.status)
                    report_mismatch("status", 32'(exp_r.status), 32'(m_axis_tdata[39:38]));
                if (m_axis_tdata[50:40] !== exp_r.remaining)
                    report_mismatch("bits_remaining", 32'(exp_r.remaining),
                                    32'(m_axis_tdata[50:40]));
                if (m_axis_tdata[55:51] !== '0)
                    report_mismatch("padding", '0, 32'(m_axis_tdata[55:51]));
            end
        end
    end

    // watchdog: too long with no handshake on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $time, quiet_cycles);
            $display("** six_bit_armor_field_extractor_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        shadow_wr     = 0;
        shadow_rd     = 0;
        shadow_left   = 0;
        shadow_left_n = 0;
        foreach (sym_shadow[i]) sym_shadow[i] = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_full_store();
        test_backpressure();
        test_random_streams();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_fields.size() == 0) begin
            $display("** six_bit_armor_field_extractor_core: PASSED **");
        end else begin
            $display("** six_bit_armor_field_extractor_core: FAILED **");
        end
        $finish;
    end

endmodule
